@@ rtl/core/ffea_pkg.sv @@
// ---------------------------------------------------------------------------
// ffea_pkg: shared definitions for the first-fit extent allocator
// Sizes, command and status codes, the table entry layout and the FSM states.
// ---------------------------------------------------------------------------
package ffea_pkg;

  // Table geometry
  localparam int MAX_EXTENTS = 16;
  localparam int ADDR_BITS   = 20;
  localparam int LEN_W       = 21;
  localparam int OUT_ADDR_W  = 20;
  localparam int STATUS_W    = 3;
  localparam int USE_W       = 5;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

  // Running end address needs headroom for start + length + request
  localparam int SPAN_W = (ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W;
  localparam int CUR_W  = SPAN_W + 2;

  localparam logic [CUR_W-1:0] ADDR_SPAN         = CUR_W'(1) << ADDR_BITS;
  localparam logic [LEN_W-1:0] DEVICE_SIZE_RESET = LEN_W'(1) << 20;

  // Command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_PLACED   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

  // One table entry as held in the extent memory
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     length;
  } extent_t;

  localparam int EXTENT_W = $bits(extent_t);

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_SHIFT,
    S_DRAIN,
    S_INSERT,
    S_RELEASE,
    S_FINISH
  } state_t;

endpackage

@@ rtl/core/ffea_ram.sv @@
// ---------------------------------------------------------------------------
// ffea_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ffea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/first_fit_extent_allocator_core.sv @@
// ---------------------------------------------------------------------------
// first_fit_extent_allocator_core: first-fit extent table with one RAM
// Places and releases extents in an address-sorted table held in memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command and request_length.
//   An allocate walks the table from the lowest address and takes the first
//   gap strictly larger than the length, else the tail space if the length
//   is strictly smaller than it. A release drops the lowest-address extent.
//   Output channel (out_valid/out_ready) returns status, start_address and
//   entries_in_use. cfg_write_en/cfg_write_data set device_size at any edge.
// Sequencing:
//   The table is a circular buffer in one RAM, so a release is one read.
//   Table full and release on an empty table go straight to the result.
//   An allocate reads one entry a cycle while scanning, then moves the
//   entries from the insert point up one a cycle through the single read
//   and write ports and writes the new entry in the gap or the tail space.
//   One item is in flight at a time; in_ready is high while idle.
// Reset: table empty, device_size back to 1048576, no result pending.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and holds in its last step until the register frees.
// ---------------------------------------------------------------------------
module first_fit_extent_allocator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [ffea_pkg::LEN_W-1:0]         cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [ffea_pkg::LEN_W-1:0]         request_length,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffea_pkg::STATUS_W-1:0]      status,
  output logic [ffea_pkg::OUT_ADDR_W-1:0]    start_address,
  output logic [ffea_pkg::USE_W-1:0]         entries_in_use
);

  import ffea_pkg::*;

  // Map a logical table index onto the circular buffer
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] i);
    logic [IDX_W+1:0] s;
    s = (IDX_W+2)'(h) + (IDX_W+2)'(i);
    if (s >= (IDX_W+2)'(MAX_EXTENTS)) begin
      s = s - (IDX_W+2)'(MAX_EXTENTS);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t state, state_next;

  logic [LEN_W-1:0]      device_size;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      head;
  logic                  cmd_q;
  logic [LEN_W-1:0]      len_q;
  logic [CUR_W-1:0]      cur;
  logic [CNT_W-1:0]      ev_i;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W-1:0]      sh;
  logic                  pend_valid;
  logic [CNT_W-1:0]      pend_dst;
  logic [STATUS_W-1:0]   res_status;
  logic [OUT_ADDR_W-1:0] res_start;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  extent_t               rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  extent_t               wr_data;

  logic                  in_fire;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_last;
  logic [CUR_W-1:0]      cur_plus_len;
  logic [CUR_W-1:0]      usable;
  logic                  gap_fit;
  logic                  tail_fit;
  logic [CUR_W-1:0]      entry_end;

  // Extent table
  ffea_ram #(
    .WIDTH (EXTENT_W),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and fit tests
  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign cnt_last     = count - CNT_W'(1);
  assign cur_plus_len = cur + CUR_W'(len_q);
  assign usable       = (CUR_W'(device_size) > ADDR_SPAN) ? ADDR_SPAN : CUR_W'(device_size);
  assign gap_fit      = CUR_W'(rd_data.start) > cur_plus_len;
  assign tail_fit     = cur_plus_len < usable;
  assign entry_end    = CUR_W'(rd_data.start) + CUR_W'(rd_data.length);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (command == CMD_RELEASE) begin
            state_next = (count == '0) ? S_FINISH : S_RELEASE;
          end else if (count == CNT_W'(MAX_EXTENTS)) begin
            state_next = S_FINISH;
          end else if (count == '0) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (gap_fit) begin
          state_next = S_SHIFT;
        end else if (ev_i == cnt_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL:    state_next = tail_fit ? S_INSERT : S_FINISH;
      S_SHIFT:   state_next = (sh == pos) ? S_DRAIN : S_SHIFT;
      S_DRAIN:   state_next = S_INSERT;
      S_INSERT:  state_next = S_FINISH;
      S_RELEASE: state_next = S_FINISH;
      S_FINISH:  state_next = out_free ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys(head, pend_dst);
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_fire;
        rd_addr = head;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, CNT_W'(ev_i + CNT_W'(1)));
      end
      S_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, sh);
        wr_en   = pend_valid;
      end
      S_DRAIN: begin
        wr_en = 1'b1;
      end
      S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, pos);
        wr_data = '{start: ADDR_BITS'(cur), length: len_q};
      end
      S_TAIL, S_RELEASE, S_FINISH: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      device_size <= DEVICE_SIZE_RESET;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        device_size <= cfg_write_data;
      end
    end
  end

  // Table bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      head       <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (state == S_SCAN) begin
        pend_valid <= 1'b0;
      end else if (state == S_SHIFT) begin
        pend_valid <= 1'b1;
      end
      // Load the next result, or drop the current one once taken
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
        if (res_status == STATUS_PLACED) begin
          count <= count + CNT_W'(1);
        end else if (res_status == STATUS_RELEASED) begin
          count <= cnt_last;
          head  <= phys(head, CNT_W'(1));
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q      <= command;
          len_q      <= request_length;
          cur        <= '0;
          ev_i       <= '0;
          res_start  <= '0;
          if (command == CMD_RELEASE) begin
            res_status <= STATUS_EMPTY;
          end else begin
            res_status <= STATUS_FULL;
          end
        end
      end
      S_SCAN: begin
        if (gap_fit) begin
          pos        <= ev_i;
          sh         <= cnt_last;
          res_status <= STATUS_PLACED;
          res_start  <= OUT_ADDR_W'(cur);
        end else begin
          cur  <= entry_end;
          ev_i <= ev_i + CNT_W'(1);
        end
      end
      S_TAIL: begin
        pos <= count;
        if (tail_fit) begin
          res_status <= STATUS_PLACED;
          res_start  <= OUT_ADDR_W'(cur);
        end else begin
          res_status <= STATUS_NO_ROOM;
          res_start  <= '0;
        end
      end
      S_SHIFT: begin
        pend_dst <= sh + CNT_W'(1);
        if (sh != pos) begin
          sh <= sh - CNT_W'(1);
        end
      end
      S_RELEASE: begin
        res_status <= STATUS_RELEASED;
        res_start  <= OUT_ADDR_W'(rd_data.start);
      end
      default: begin
        cmd_q <= cmd_q;
      end
    endcase
  end

  // Result fields, loaded when the output register frees
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      status        <= res_status;
      start_address <= res_start;
      if (res_status == STATUS_PLACED) begin
        entries_in_use <= USE_W'(count + CNT_W'(1));
      end else if (res_status == STATUS_RELEASED) begin
        entries_in_use <= USE_W'(cnt_last);
      end else begin
        entries_in_use <= USE_W'(count);
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_EXTENTS))
    else $error("extent count beyond table size");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (sh >= pos && pos < count))
    else $error("shift pointer below insert point");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> (count < CNT_W'(MAX_EXTENTS) && cmd_q == CMD_ALLOC))
    else $error("insert into a full table or on release");

  a_release_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELEASE) |-> (count != '0 && cmd_q == CMD_RELEASE))
    else $error("release from an empty table");

endmodule
